// ----- design/flr_pkg.sv -----
// Shared types, coefficients and binary32 arithmetic helpers for the log2 pipeline.
// No dependencies; every other design file imports this package.
`default_nettype none
package flr_pkg;

    // Polynomial coefficients as binary32 bit patterns.
    localparam logic [31:0] C0_BITS = 32'h3FB89C4E;
    localparam logic [31:0] C1_BITS = 32'hBF3967BA;
    localparam logic [31:0] C2_BITS = 32'h3F02EF1C;
    localparam logic [31:0] C3_BITS = 32'hBEA83F70;
    // Fraction of the mantissa threshold (about the square root of two).
    localparam logic [22:0] LIMIT_FRAC = 23'h3504F3;

    localparam logic [31:0] NEG_INF = 32'hFF800000;
    localparam logic [31:0] POS_INF = 32'h7F800000;
    localparam logic [31:0] QNAN    = 32'h7FC00000;

    typedef struct packed {
        logic        special;
        logic [31:0] spec_bits;
        logic [31:0] t;
        logic [31:0] exf;
    } t_side;

    // Index of the highest set bit; zero input gives zero.
    function automatic logic [4:0] msb24(input logic [23:0] v);
        logic [4:0] k;
        k = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) k = 5'(i);
        end
        return k;
    endfunction

    // Round-to-nearest-even binary32 product; operands are normal or zero and
    // the result stays in the normal range.
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [47:0] pr;
        logic [9:0]  e;
        logic [23:0] m;
        logic        g;
        logic        st;
        logic [24:0] mr;
        s  = a[31] ^ b[31];
        pr = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        e  = {2'b00, a[30:23]} + {2'b00, b[30:23]} - 10'd127;
        if (pr[47]) begin
            m  = pr[47:24];
            g  = pr[23];
            st = |pr[22:0];
            e  = e + 10'd1;
        end else begin
            m  = pr[46:23];
            g  = pr[22];
            st = |pr[21:0];
        end
        mr = {1'b0, m} + {24'd0, g & (st | m[0])};
        if (mr[24]) begin
            m = mr[24:1];
            e = e + 10'd1;
        end else begin
            m = mr[23:0];
        end
        if (a[30:23] == 8'd0 || b[30:23] == 8'd0) return {s, 31'd0};
        return {s, e[7:0], m[22:0]};
    endfunction

    // Round-to-nearest-even binary32 sum under the same range assumptions.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  d;
        logic [26:0] av;
        logic [26:0] bv;
        logic [26:0] bs;
        logic [26:0] mask;
        logic [27:0] sm;
        logic [9:0]  e;
        logic [4:0]  lz;
        logic [26:0] nm;
        logic [24:0] mr;
        logic [23:0] m;
        logic        g;
        logic        st;
        if (a[30:0] == 31'd0) return b;
        if (b[30:0] == 31'd0) return a;
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        d  = x[30:23] - y[30:23];
        av = {1'b1, x[22:0], 3'b000};
        bv = {1'b1, y[22:0], 3'b000};
        if (d >= 8'd27) begin
            bs = 27'd1;
        end else begin
            mask = (27'd1 << d) - 27'd1;
            bs   = bv >> d;
            bs[0] = bs[0] | (|(bv & mask));
        end
        if (x[31] == y[31]) sm = {1'b0, av} + {1'b0, bs};
        else                sm = {1'b0, av} - {1'b0, bs};
        if (sm == 28'd0) return 32'd0;
        e = {2'b00, x[30:23]};
        if (sm[27]) begin
            nm = sm[27:1] | {26'd0, sm[0]};
            e  = e + 10'd1;
        end else begin
            lz = 5'd0;
            for (int i = 0; i < 27; i++) begin
                if (sm[i]) lz = 5'(26 - i);
            end
            nm = sm[26:0] << lz;
            e  = e - {5'd0, lz};
        end
        m  = nm[26:3];
        g  = nm[2];
        st = nm[1] | nm[0];
        mr = {1'b0, m} + {24'd0, g & (st | m[0])};
        if (mr[24]) begin
            m = mr[24:1];
            e = e + 10'd1;
        end else begin
            m = mr[23:0];
        end
        return {x[31], e[7:0], m[22:0]};
    endfunction

endpackage
`default_nettype wire

// ----- design/flr_unpack.sv -----
// First pipeline stage: special-case decode, exponent/mantissa split and reduction.
// Depends on flr_pkg.
`default_nettype none
module flr_unpack
    import flr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_x_bits,
    output logic             o_valid,
    output t_side            o_side
);
    logic        r_valid;
    t_side       r_side;
    t_side       n_side;
    logic [7:0]  ef;
    logic [22:0] fr;
    logic [22:0] frn;
    logic [4:0]  k;
    logic [4:0]  s;
    logic signed [9:0] ex;
    logic        below;
    logic [23:0] q;
    logic [4:0]  j;
    logic [7:0]  aex;
    logic [4:0]  je;

    always_comb begin
        ef = i_x_bits[30:23];
        fr = i_x_bits[22:0];
        k  = msb24({1'b0, fr});
        s  = 5'd23 - k;
        if (ef == 8'd0) begin
            frn = 23'(fr << s);
            ex  = -10'sd125 - $signed({5'd0, s});
        end else begin
            frn = fr;
            ex  = $signed({2'b00, ef}) - 10'sd126;
        end
        below = frn < LIMIT_FRAC;
        if (below) ex = ex - 10'sd1;

        // Reduced mantissa minus one is exact; build it from its integer numerator.
        // Above the threshold it is negative, -(2^23 - frac) / 2^24; below it is
        // frac / 2^23 after the doubling.
        n_side.t = 32'd0;
        if (!below) begin
            q = 24'h800000 - {1'b0, frn};
            j = msb24(q);
            n_side.t = {1'b1, 8'(j + 5'd0) + 8'd103, 23'(q << (5'd23 - j))};
        end else begin
            q = {1'b0, frn};
            j = msb24(q);
            if (frn != 23'd0)
                n_side.t = {1'b0, 8'(j) + 8'd104, 23'(q << (5'd23 - j))};
        end

        aex = ex[9] ? 8'(-ex) : 8'(ex);
        je  = msb24({16'd0, aex});
        if (aex == 8'd0) n_side.exf = 32'd0;
        else n_side.exf = {ex[9], 8'(je) + 8'd127, 23'({16'd0, aex} << (5'd23 - je))};

        n_side.special   = 1'b1;
        n_side.spec_bits = 32'd0;
        if (ef == 8'hFF && fr != 23'd0)      n_side.spec_bits = i_x_bits;
        else if (i_x_bits[30:0] == 31'd0)    n_side.spec_bits = NEG_INF;
        else if (i_x_bits[31])               n_side.spec_bits = QNAN;
        else if (ef == 8'hFF)                n_side.spec_bits = POS_INF;
        else                                 n_side.special   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side <= n_side;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ----- design/flr_mul_stage.sv -----
// One pipeline stage holding a rounded binary32 multiply.
// Depends on flr_pkg.
`default_nettype none
module flr_mul_stage
    import flr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_side       i_side,
    input  wire logic [31:0] i_b,
    output logic             o_valid,
    output t_side            o_side,
    output logic [31:0]      o_p
);
    logic        r_valid;
    t_side       r_side;
    logic [31:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side <= i_side;
        r_p    <= fp_mul(i_side.t, i_b);
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_p     = r_p;
endmodule
`default_nettype wire

// ----- design/flr_add_stage.sv -----
// One pipeline stage holding a rounded binary32 add.
// Depends on flr_pkg.
`default_nettype none
module flr_add_stage
    import flr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_side       i_side,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_valid,
    output t_side            o_side,
    output logic [31:0]      o_p
);
    logic        r_valid;
    t_side       r_side;
    logic [31:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side <= i_side;
        r_p    <= fp_add(i_a, i_b);
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_p     = r_p;
endmodule
`default_nettype wire

// ----- design/float_log2_reduced_accuracy.sv -----
// Approximate binary32 log2: a nine-stage pipeline, one beat accepted every cycle.
// From start to o_valid each beat passes one unpack stage, seven stages each holding
// one rounded multiply or add of the polynomial, and the final exponent add.
// busy is always low and the receiver cannot stall; results are not held.
// Synchronous active-low reset clears the valid bits only. Depends on flr_pkg.
`default_nettype none
module float_log2_reduced_accuracy
    import flr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_x_bits,
    output logic             o_valid,
    output logic [31:0]      o_log2_bits
);
    logic        v [0:8];
    t_side       sd [0:8];
    logic [31:0] p [1:8];

    assign busy = 1'b0;

    flr_unpack u_unpack (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .i_x_bits(i_x_bits),
        .o_valid(v[0]), .o_side(sd[0])
    );

    flr_mul_stage u_m1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[0]), .i_side(sd[0]),
        .i_b(C3_BITS), .o_valid(v[1]), .o_side(sd[1]), .o_p(p[1]));
    flr_add_stage u_a2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[1]), .i_side(sd[1]),
        .i_a(C2_BITS), .i_b(p[1]), .o_valid(v[2]), .o_side(sd[2]), .o_p(p[2]));
    flr_mul_stage u_m3 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[2]), .i_side(sd[2]),
        .i_b(p[2]), .o_valid(v[3]), .o_side(sd[3]), .o_p(p[3]));
    flr_add_stage u_a4 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[3]), .i_side(sd[3]),
        .i_a(C1_BITS), .i_b(p[3]), .o_valid(v[4]), .o_side(sd[4]), .o_p(p[4]));
    flr_mul_stage u_m5 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[4]), .i_side(sd[4]),
        .i_b(p[4]), .o_valid(v[5]), .o_side(sd[5]), .o_p(p[5]));
    flr_add_stage u_a6 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[5]), .i_side(sd[5]),
        .i_a(C0_BITS), .i_b(p[5]), .o_valid(v[6]), .o_side(sd[6]), .o_p(p[6]));
    flr_mul_stage u_m7 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[6]), .i_side(sd[6]),
        .i_b(p[6]), .o_valid(v[7]), .o_side(sd[7]), .o_p(p[7]));
    // The exponent goes in as operand a so that a zero exponent returns the polynomial.
    flr_add_stage u_a8 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[7]), .i_side(sd[7]),
        .i_a(sd[7].exf), .i_b(p[7]), .o_valid(v[8]), .o_side(sd[8]), .o_p(p[8]));

    assign o_valid     = v[8];
    assign o_log2_bits = sd[8].special ? sd[8].spec_bits : p[8];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##9 o_valid) else $error("result beat missing");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##9 !o_valid) else $error("unexpected result beat");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_x_bits[30:0] == 31'd0) |-> ##9 (o_log2_bits == NEG_INF))
        else $error("zero operand did not give minus infinity");
    a_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_x_bits[31] && i_x_bits[30:0] != 31'd0 && i_x_bits[30:23] != 8'hFF)
        |-> ##9 (o_log2_bits == QNAN)) else $error("negative operand did not give NaN");
endmodule
`default_nettype wire
